[hw/rtl/odo_pkg.sv]
package odo_pkg;

  // coordinate and counter widths
  localparam int COORD_BITS = 15;
  localparam int COUNT_BITS = 40;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // square root unit: radicand up to 2 * (2^15 - 1)^2
  localparam int RAD_BITS   = 2 * COORD_BITS + 2;
  localparam int ROOT_BITS  = RAD_BITS / 2;
  localparam int SQRT_STEPS = RAD_BITS / 2;
  localparam int STEP_BITS  = $clog2(SQRT_STEPS);
  localparam int SHIFT_BITS = $clog2(RAD_BITS);

  // movement time bookkeeping: whole seconds plus leftover milliseconds
  localparam int SEC_BITS    = 32;
  localparam int MS_BITS     = 10;
  localparam int GAP_BITS    = 16;
  localparam int ACC_MS_BITS = GAP_BITS + 1;
  localparam int QUOT_BITS   = 7;
  localparam int MS_PER_S    = 1000;
  // q = (v * RECIP) >> RECIP_SHIFT is floor(v / 1000) or one more
  localparam int RECIP       = 1049;
  localparam int RECIP_SHIFT = 20;

  // shared multiplier
  localparam int MUL_BITS  = 17;
  localparam int PROD_BITS = 2 * MUL_BITS;

  // event kinds
  localparam int OP_BITS = 2;
  localparam logic [OP_BITS-1:0] OP_MOVE   = 2'd0;
  localparam logic [OP_BITS-1:0] OP_BUTTON = 2'd1;
  localparam logic [OP_BITS-1:0] OP_KEY    = 2'd2;
  localparam logic [OP_BITS-1:0] OP_NONE   = 2'd3;

  // register map
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_JUMP      = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GAP       = 2'd3;

  // stream words
  localparam int IN_DATA_BITS  = 88;
  localparam int OUT_DATA_BITS = 192;
  localparam int KEY_LSB       = 152;
  localparam int CLICK_CNT_LSB = 112;

endpackage

[hw/rtl/odo_isqrt.sv]
module odo_isqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [odo_pkg::RAD_BITS-1:0]  radicand,
  output logic                          busy,
  output logic [odo_pkg::ROOT_BITS-1:0] root
);
  import odo_pkg::*;

  logic [RAD_BITS-1:0]   rad_r;
  logic [RAD_BITS-1:0]   res_r;
  logic [STEP_BITS-1:0]  cnt_r;
  logic                  busy_r;
  logic [SHIFT_BITS-1:0] shift;
  logic [RAD_BITS-1:0]   bit_w;
  logic [RAD_BITS-1:0]   trial;

  // one result bit per step, bit weight drops by a factor of four each step
  assign shift = SHIFT_BITS'(RAD_BITS - 2) - {cnt_r, 1'b0};
  assign bit_w = RAD_BITS'(1) << shift;
  assign trial = res_r + bit_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      rad_r  <= radicand;
      res_r  <= '0;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      if (rad_r >= trial) begin
        rad_r <= rad_r - trial;
        res_r <= (res_r >> 1) + bit_w;
      end else begin
        res_r <= res_r >> 1;
      end
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == STEP_BITS'(SQRT_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign root = res_r[ROOT_BITS-1:0];

endmodule

[hw/rtl/input_activity_odometer.sv]
// Input activity odometer: keeps saturating totals of pointer travel,
// movement time, click-to-click travel, button presses and keystrokes.
//
// in_*  : one event per word. tuser = op (0 move, 1 button, 2 key).
// cfg_* : register writes, always ready; write only while idle.
// out_* : one word of current totals for every event taken, ignored or not.
//
// A counted move, or a click with both positions known, takes the long path
// after acceptance: a decode step, two squarings on the shared 17x17
// multiplier, 16 steps of the square root unit (one root bit a step), during
// which the multiplier also splits the movement gap into seconds, a final add
// and the output load. Other events go from the decode step straight to the
// output load. in_tready is high only while no event is in progress, so a new
// event is taken only after the last one has been loaded for output.
//
// Reset clears all totals and position history and loads the register
// defaults (disabled, threshold 3, jump limit 10000, gap limit 1000 ms).
// A stalled receiver holds the result in the output register; the next
// event is still taken and its result waits until that register frees.
module input_activity_odometer (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // pos_x[15:0], pos_y[31:16], wheel[47:32], time_ms[79:48],
  // pressed[80], key_repeat[81], zero[87:82]
  input  logic [odo_pkg::IN_DATA_BITS-1:0]      in_tdata,
  // op[1:0]
  input  logic [odo_pkg::OP_BITS-1:0]           in_tuser,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // movement_total[39:0], movement_seconds[71:40], click_travel[111:72],
  // click_count[151:112], key_count[191:152]
  output logic [odo_pkg::OUT_DATA_BITS-1:0]     out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [odo_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [odo_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import odo_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MULX = 3'd2;
  localparam logic [2:0] ST_MULY = 3'd3;
  localparam logic [2:0] ST_DIVQ = 3'd4;
  localparam logic [2:0] ST_DIVR = 3'd5;
  localparam logic [2:0] ST_ROOT = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0] state_r;

  // configuration
  logic                  enable_r;
  logic [7:0]            thr_r;
  logic [COORD_BITS-1:0] jump_r;
  logic [GAP_BITS-1:0]   gapl_r;

  // captured event
  logic [OP_BITS-1:0] op_r;
  logic [15:0]        px_r, py_r, wheel_r;
  logic [31:0]        time_r;
  logic               pressed_r, krep_r;

  // history and totals
  logic                  last_valid_r, click_valid_r, time_valid_r;
  logic [COORD_BITS-1:0] last_x_r, last_y_r, click_x_r, click_y_r;
  logic [31:0]           last_time_r;
  logic [SEC_BITS-1:0]   sec_r;
  logic [MS_BITS-1:0]    ms_r;
  logic [COUNT_BITS-1:0] travel_r, ctrav_r, press_r, key_r;

  // working registers
  logic [COORD_BITS-1:0]   dx_r, dy_r;
  logic [2*COORD_BITS-1:0] sq_r;
  logic [ACC_MS_BITS-1:0]  v_r;
  logic [QUOT_BITS-1:0]    q_r;
  logic                    to_click_r;

  logic                     out_valid_r;
  logic [OUT_DATA_BITS-1:0] out_data_r;
  logic                     out_load;

  // decode-cycle values
  logic [COORD_BITS-1:0] x, y, adx, ady, dxm, dym, cdx, cdy, thr_w;
  logic                  neg, counted, gap_ok, in_acc, prep_long;
  logic [31:0]           gap;

  // shared multiplier
  logic [MUL_BITS-1:0]  mul_a, mul_b;
  logic [PROD_BITS-1:0] prod;

  // seconds split
  logic [ACC_MS_BITS:0]  rem_raw;
  logic [QUOT_BITS-1:0]  q_fix;
  logic [ACC_MS_BITS:0]  rem_fix;
  logic [SEC_BITS:0]     sec_sum;

  // root and accumulation
  logic                  sq_start, sq_busy;
  logic [RAD_BITS-1:0]   radicand;
  logic [ROOT_BITS-1:0]  root;
  logic [COUNT_BITS:0]   trav_sum, ctrav_sum, press_sum, key_sum;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    x     = px_r[COORD_BITS-1:0];
    y     = py_r[COORD_BITS-1:0];
    neg   = px_r[15] || py_r[15];
    thr_w = COORD_BITS'(thr_r);
    adx   = (x > last_x_r) ? x - last_x_r : last_x_r - x;
    ady   = (y > last_y_r) ? y - last_y_r : last_y_r - y;
    dxm   = last_valid_r ? adx : thr_w;
    dym   = last_valid_r ? ady : thr_w;
    counted = (dxm < jump_r) && (dym < jump_r) &&
              ((dxm >= thr_w) || (dym >= thr_w) || (wheel_r != '0));
    gap     = time_r - last_time_r;
    gap_ok  = time_valid_r && (gap < 32'(gapl_r));
    cdx = (click_x_r > last_x_r) ? click_x_r - last_x_r : last_x_r - click_x_r;
    cdy = (click_y_r > last_y_r) ? click_y_r - last_y_r : last_y_r - click_y_r;
    // events that need a square root take the long path
    prep_long = enable_r &&
                (((op_r == OP_MOVE) && !neg && counted) ||
                 ((op_r == OP_BUTTON) && click_valid_r && last_valid_r));
  end

  always_comb begin
    unique case (state_r)
      ST_MULX: begin
        mul_a = MUL_BITS'(dx_r);
        mul_b = MUL_BITS'(dx_r);
      end
      ST_MULY: begin
        mul_a = MUL_BITS'(dy_r);
        mul_b = MUL_BITS'(dy_r);
      end
      ST_DIVQ: begin
        mul_a = v_r;
        mul_b = MUL_BITS'(RECIP);
      end
      default: begin
        mul_a = MUL_BITS'(q_r);
        mul_b = MUL_BITS'(MS_PER_S);
      end
    endcase
  end

  assign prod = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // estimate is exact or one too large; one compare fixes it
  always_comb begin
    rem_raw = {1'b0, v_r} - prod[ACC_MS_BITS:0];
    if (rem_raw[ACC_MS_BITS]) begin
      q_fix   = q_r - 1'b1;
      rem_fix = rem_raw + (ACC_MS_BITS+1)'(MS_PER_S);
    end else begin
      q_fix   = q_r;
      rem_fix = rem_raw;
    end
    sec_sum = {1'b0, sec_r} + (SEC_BITS+1)'(q_fix);
  end

  assign sq_start = (state_r == ST_MULY);
  assign radicand = RAD_BITS'(sq_r) + RAD_BITS'(prod[2*COORD_BITS-1:0]);

  odo_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (radicand),
    .busy     (sq_busy),
    .root     (root)
  );

  assign trav_sum  = {1'b0, travel_r} + (COUNT_BITS+1)'(root);
  assign ctrav_sum = {1'b0, ctrav_r} + (COUNT_BITS+1)'(root);
  assign press_sum = {1'b0, press_r} + 1'b1;
  assign key_sum   = {1'b0, key_r} + 1'b1;

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      enable_r      <= 1'b0;
      thr_r         <= 8'd3;
      jump_r        <= COORD_BITS'(10000);
      gapl_r        <= GAP_BITS'(1000);
      last_valid_r  <= 1'b0;
      click_valid_r <= 1'b0;
      time_valid_r  <= 1'b0;
      last_x_r      <= '0;
      last_y_r      <= '0;
      click_x_r     <= '0;
      click_y_r     <= '0;
      last_time_r   <= '0;
      sec_r         <= '0;
      ms_r          <= '0;
      travel_r      <= '0;
      ctrav_r       <= '0;
      press_r       <= '0;
      key_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ENABLE:    enable_r <= cfg_data[0];
          CFG_THRESHOLD: thr_r    <= cfg_data[7:0];
          CFG_JUMP:      jump_r   <= cfg_data[COORD_BITS-1:0];
          CFG_GAP:       gapl_r   <= cfg_data;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r      <= in_tuser;
            px_r      <= in_tdata[15:0];
            py_r      <= in_tdata[31:16];
            wheel_r   <= in_tdata[47:32];
            time_r    <= in_tdata[79:48];
            pressed_r <= in_tdata[80];
            krep_r    <= in_tdata[81];
            state_r   <= ST_PREP;
          end
        end
        ST_PREP: begin
          state_r <= prep_long ? ST_MULX : ST_DONE;
          priority if (enable_r && op_r == OP_MOVE && !neg) begin
            last_x_r     <= x;
            last_y_r     <= y;
            last_valid_r <= 1'b1;
            if (counted) begin
              dx_r         <= dxm;
              dy_r         <= dym;
              to_click_r   <= 1'b0;
              v_r          <= (ACC_MS_BITS)'(ms_r) +
                              (gap_ok ? (ACC_MS_BITS)'(gap[GAP_BITS-1:0]) : '0);
              last_time_r  <= time_r;
              time_valid_r <= 1'b1;
            end
          end else if (enable_r && op_r == OP_BUTTON) begin
            click_x_r     <= last_x_r;
            click_y_r     <= last_y_r;
            click_valid_r <= last_valid_r;
            if (pressed_r) begin
              press_r <= press_sum[COUNT_BITS] ? COUNT_MAX : press_sum[COUNT_BITS-1:0];
            end
            if (click_valid_r && last_valid_r) begin
              dx_r       <= cdx;
              dy_r       <= cdy;
              to_click_r <= 1'b1;
              v_r        <= (ACC_MS_BITS)'(ms_r);
            end
          end else if (enable_r && op_r == OP_KEY && !krep_r) begin
            key_r <= key_sum[COUNT_BITS] ? COUNT_MAX : key_sum[COUNT_BITS-1:0];
          end else begin
            // disabled, unknown op, invalid position or repeat key
          end
        end
        ST_MULX: begin
          sq_r    <= prod[2*COORD_BITS-1:0];
          state_r <= ST_MULY;
        end
        ST_MULY: begin
          state_r <= ST_DIVQ;
        end
        ST_DIVQ: begin
          q_r     <= prod[RECIP_SHIFT+QUOT_BITS-1:RECIP_SHIFT];
          state_r <= ST_DIVR;
        end
        ST_DIVR: begin
          sec_r   <= sec_sum[SEC_BITS] ? '1 : sec_sum[SEC_BITS-1:0];
          ms_r    <= rem_fix[MS_BITS-1:0];
          state_r <= ST_ROOT;
        end
        ST_ROOT: begin
          if (!sq_busy) begin
            if (to_click_r) begin
              ctrav_r <= ctrav_sum[COUNT_BITS] ? COUNT_MAX : ctrav_sum[COUNT_BITS-1:0];
            end else begin
              travel_r <= trav_sum[COUNT_BITS] ? COUNT_MAX : trav_sum[COUNT_BITS-1:0];
            end
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_data_r <= {key_r, press_r, ctrav_r, sec_r, travel_r};
            state_r    <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[hw/rtl/odo_checker.sv]
module odo_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [odo_pkg::OUT_DATA_BITS-1:0]   out_tdata
);
  import odo_pkg::*;

  // one event at a time: taking a word closes the input side
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an event is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result word changed");

  // key and click counts only ever grow
  a_keys_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && $past(out_tvalid)) |->
      (out_tdata[KEY_LSB +: COUNT_BITS] >= $past(out_tdata[KEY_LSB +: COUNT_BITS])))
    else $error("key count went down");

  a_clicks_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && $past(out_tvalid)) |->
      (out_tdata[CLICK_CNT_LSB +: COUNT_BITS] >=
       $past(out_tdata[CLICK_CNT_LSB +: COUNT_BITS])))
    else $error("click count went down");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!out_tvalid && in_tready))
    else $error("block not quiet after reset");

endmodule

bind input_activity_odometer odo_checker u_odo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
